// ===== src/mccu_pkg.sv =====
// Shared types and constants for the multicycle control unit.
// No dependencies; imported by mccu_seq and the top level.
`timescale 1ns / 1ps

package mccu_pkg;

    // field widths
    localparam int OpcodeWidth = 6;
    localparam int FuncWidth   = 6;
    localparam int CwWidth     = 19;
    localparam int AluWidth    = 3;
    localparam int StateWidth  = 5;

    // opcodes
    localparam logic [OpcodeWidth-1:0] OP_RTYPE = 6'd0;
    localparam logic [OpcodeWidth-1:0] OP_J     = 6'd2;
    localparam logic [OpcodeWidth-1:0] OP_JAL   = 6'd3;
    localparam logic [OpcodeWidth-1:0] OP_BEQ   = 6'd4;
    localparam logic [OpcodeWidth-1:0] OP_BNE   = 6'd5;
    localparam logic [OpcodeWidth-1:0] OP_ADDI  = 6'd8;
    localparam logic [OpcodeWidth-1:0] OP_ANDI  = 6'd12;
    localparam logic [OpcodeWidth-1:0] OP_JR    = 6'd20;
    localparam logic [OpcodeWidth-1:0] OP_JALR  = 6'd21;
    localparam logic [OpcodeWidth-1:0] OP_LW    = 6'd35;
    localparam logic [OpcodeWidth-1:0] OP_SW    = 6'd43;

    // r-type function codes
    localparam logic [FuncWidth-1:0] FN_ADD = 6'h20;
    localparam logic [FuncWidth-1:0] FN_SUB = 6'h22;
    localparam logic [FuncWidth-1:0] FN_AND = 6'h24;
    localparam logic [FuncWidth-1:0] FN_OR  = 6'h25;
    localparam logic [FuncWidth-1:0] FN_SLT = 6'h2a;

    // aluop field of the control word
    localparam logic [1:0] ALUOP_ADD   = 2'b00;
    localparam logic [1:0] ALUOP_SUB   = 2'b01;
    localparam logic [1:0] ALUOP_FUNC  = 2'b10;
    localparam logic [1:0] ALUOP_AND   = 2'b11;

    // alu operation codes
    localparam logic [AluWidth-1:0] ALU_AND = 3'd0;
    localparam logic [AluWidth-1:0] ALU_OR  = 3'd1;
    localparam logic [AluWidth-1:0] ALU_ADD = 3'd2;
    localparam logic [AluWidth-1:0] ALU_SUB = 3'd6;
    localparam logic [AluWidth-1:0] ALU_SLT = 3'd7;

    // one result beat as produced by the sequencer
    typedef struct packed {
        logic [CwWidth-1:0]    control_word;
        logic [AluWidth-1:0]   alu_operation;
        logic                  func_error;
        logic [StateWidth-1:0] present_state;
    } mccu_result_t;

endpackage

// ===== src/multicycle_cpu_control_unit_core.sv =====
// Top level of the multicycle control unit: input register, sequencer, result register.
// Depends on mccu_pkg and mccu_seq.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------------
//   req     | in        | req_valid, req_stall | opcode, func_code
//   rsp     | out       | rsp_valid, rsp_stall | control_word, alu_operation, func_error,
//           |           |                      | present_state
//
// One beat is accepted every cycle while req_stall is low; results are registered.
// The sequencer sits between the input register and the result register and steps its
// state once per beat, so throughput is set only by request gaps and the result stall.
// Reset puts the sequencer in instruction fetch with a held alu op of and.
// A stalled result holds in its register; the input register keeps taking beats until
// both stages are full.
`timescale 1ns / 1ps

module multicycle_cpu_control_unit_core
    import mccu_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  logic [OpcodeWidth-1:0] opcode,
    input  logic [FuncWidth-1:0]   func_code,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output logic [CwWidth-1:0]     control_word,
    output logic [AluWidth-1:0]    alu_operation,
    output logic                   func_error,
    output logic [StateWidth-1:0]  present_state
);

    logic                   in_valid_reg;
    logic [OpcodeWidth-1:0] in_opcode_reg;
    logic [FuncWidth-1:0]   in_func_reg;
    logic                   out_valid_reg;
    mccu_result_t           out_reg;
    mccu_result_t           seq_result;
    logic                   out_free;
    logic                   step;
    logic                   req_take;

    // pipeline handshake
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign step      = in_valid_reg && out_free;
    assign req_stall = in_valid_reg && !out_free;
    assign req_take  = req_valid && !req_stall;

    mccu_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .opcode    (in_opcode_reg),
        .func_code (in_func_reg),
        .result    (seq_result)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_take)
                in_valid_reg <= 1'b1;
            else if (step)
                in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            in_opcode_reg <= opcode;
            in_func_reg   <= func_code;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_reg <= seq_result;
    end

    assign rsp_valid     = out_valid_reg;
    assign control_word  = out_reg.control_word;
    assign alu_operation = out_reg.alu_operation;
    assign func_error    = out_reg.func_error;
    assign present_state = out_reg.present_state;

endmodule

// ===== src/mccu_seq.sv =====
// Control state sequencer and alu control decoder.
// Depends on mccu_pkg for codes and the result struct.
`timescale 1ns / 1ps

module mccu_seq
    import mccu_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [OpcodeWidth-1:0] opcode,
    input  logic [FuncWidth-1:0]   func_code,
    output mccu_result_t           result
);

    typedef enum logic [StateWidth-1:0] {
        S_FETCH    = 5'd0,
        S_DECODE   = 5'd1,
        S_MEM_ADDR = 5'd2,
        S_MEM_RD   = 5'd3,
        S_LOAD_WB  = 5'd4,
        S_MEM_WR   = 5'd5,
        S_R_EXEC   = 5'd6,
        S_R_WB     = 5'd7,
        S_BEQ      = 5'd8,
        S_J        = 5'd9,
        S_JAL      = 5'd10,
        S_JR       = 5'd11,
        S_JALR     = 5'd12,
        S_ADDI     = 5'd13,
        S_ANDI     = 5'd14,
        S_BNE      = 5'd15,
        S_IMM_WB   = 5'd16
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [AluWidth-1:0]  held_alu_reg;
    logic [AluWidth-1:0]  alu_next;
    logic                 err;
    logic [CwWidth-1:0]   cw;

    // control word of the present state
    always_comb
    begin
        case (state_reg)
            S_FETCH:    cw = 19'h12810;
            S_DECODE:   cw = 19'h00030;
            S_MEM_ADDR: cw = 19'h00028;
            S_MEM_RD:   cw = 19'h03000;
            S_LOAD_WB:  cw = 19'h20004;
            S_MEM_WR:   cw = 19'h05000;
            S_R_EXEC:   cw = 19'h00088;
            S_R_WB:     cw = 19'h00005;
            S_BEQ:      cw = 19'h00548;
            S_J:        cw = 19'h00A00;
            S_JAL:      cw = 19'h40A06;
            S_JR:       cw = 19'h00B00;
            S_JALR:     cw = 19'h40B04;
            S_ADDI:     cw = 19'h00028;
            S_ANDI:     cw = 19'h000E8;
            S_BNE:      cw = 19'h08548;
            S_IMM_WB:   cw = 19'h00004;
            default:    cw = '0;
        endcase
    end

    // alu control from aluop and function field
    always_comb
    begin
        err      = 1'b0;
        alu_next = held_alu_reg;
        case (cw[7:6])
            ALUOP_FUNC:
            begin
                case (func_code)
                    FN_ADD:  alu_next = ALU_ADD;
                    FN_SUB:  alu_next = ALU_SUB;
                    FN_SLT:  alu_next = ALU_SLT;
                    FN_AND:  alu_next = ALU_AND;
                    FN_OR:   alu_next = ALU_OR;
                    default: err      = 1'b1;
                endcase
            end
            ALUOP_AND: alu_next = ALU_AND;
            ALUOP_SUB: alu_next = ALU_SUB;
            default:   alu_next = ALU_ADD;
        endcase
    end

    // next state, routed by opcode in decode and memory address
    always_comb
    begin
        case (state_reg)
            S_FETCH:  state_next = S_DECODE;
            S_DECODE:
            begin
                case (opcode)
                    OP_RTYPE:      state_next = S_R_EXEC;
                    OP_LW, OP_SW:  state_next = S_MEM_ADDR;
                    OP_BEQ:        state_next = S_BEQ;
                    OP_BNE:        state_next = S_BNE;
                    OP_J:          state_next = S_J;
                    OP_JAL:        state_next = S_JAL;
                    OP_JR:         state_next = S_JR;
                    OP_JALR:       state_next = S_JALR;
                    OP_ADDI:       state_next = S_ADDI;
                    OP_ANDI:       state_next = S_ANDI;
                    default:       state_next = S_FETCH;
                endcase
            end
            S_MEM_ADDR:
            begin
                if (opcode == OP_LW)
                    state_next = S_MEM_RD;
                else if (opcode == OP_SW)
                    state_next = S_MEM_WR;
                else
                    state_next = S_FETCH;
            end
            S_MEM_RD: state_next = S_LOAD_WB;
            S_R_EXEC: state_next = S_R_WB;
            S_ADDI:   state_next = S_IMM_WB;
            S_ANDI:   state_next = S_IMM_WB;
            default:  state_next = S_FETCH;
        endcase
    end

    assign result.control_word  = cw;
    assign result.alu_operation = alu_next;
    assign result.func_error    = err;
    assign result.present_state = state_reg;

    // state and held alu op advance once per beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_FETCH;
            held_alu_reg <= ALU_AND;
        end
        else if (step)
        begin
            state_reg    <= state_next;
            held_alu_reg <= alu_next;
        end
    end

endmodule

// ===== dv/mccu_control_checker.sv =====
// Checker for the multicycle control unit: tracks the control state and alu decode
// beat by beat and compares every result beat. Depends on mccu_pkg.
`timescale 1ns / 1ps

module mccu_control_checker
    import mccu_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    input  logic                   req_stall,
    input  logic [OpcodeWidth-1:0] opcode,
    input  logic [FuncWidth-1:0]   func_code,
    input  logic                   rsp_valid,
    input  logic                   rsp_stall,
    input  logic [CwWidth-1:0]     control_word,
    input  logic [AluWidth-1:0]    alu_operation,
    input  logic                   func_error,
    input  logic [StateWidth-1:0]  present_state,
    output int                     mismatches,
    output int                     pending,
    output int                     results_seen,
    output int                     func_errors_seen,
    output logic [16:0]            states_seen
);

    localparam int NumStates = 17;
    localparam int MaxPrinted = 50;

    // control state codes
    localparam logic [StateWidth-1:0] ST_FETCH     = 5'd0;
    localparam logic [StateWidth-1:0] ST_DECODE    = 5'd1;
    localparam logic [StateWidth-1:0] ST_MEM_ADDR  = 5'd2;
    localparam logic [StateWidth-1:0] ST_MEM_READ  = 5'd3;
    localparam logic [StateWidth-1:0] ST_LOAD_WB   = 5'd4;
    localparam logic [StateWidth-1:0] ST_MEM_WRITE = 5'd5;
    localparam logic [StateWidth-1:0] ST_R_EXEC    = 5'd6;
    localparam logic [StateWidth-1:0] ST_R_WB      = 5'd7;
    localparam logic [StateWidth-1:0] ST_BEQ       = 5'd8;
    localparam logic [StateWidth-1:0] ST_J         = 5'd9;
    localparam logic [StateWidth-1:0] ST_JAL       = 5'd10;
    localparam logic [StateWidth-1:0] ST_JR        = 5'd11;
    localparam logic [StateWidth-1:0] ST_JALR      = 5'd12;
    localparam logic [StateWidth-1:0] ST_ADDI_EXEC = 5'd13;
    localparam logic [StateWidth-1:0] ST_ANDI_EXEC = 5'd14;
    localparam logic [StateWidth-1:0] ST_BNE       = 5'd15;
    localparam logic [StateWidth-1:0] ST_IMM_WB    = 5'd16;

    // predicted machine state
    logic [StateWidth-1:0] ctl_state = ST_FETCH;
    logic [AluWidth-1:0]   held_alu  = ALU_AND;
    mccu_result_t          expected_ctl_q[$];

    mccu_result_t          next_beat;
    mccu_result_t          oldest_beat;
    logic [CwWidth-1:0]    cw;

    int                    fail_total   = 0;
    int                    result_total = 0;
    int                    error_total  = 0;
    int                    queue_depth  = 0;
    logic [NumStates-1:0]  visited      = '0;

    assign mismatches       = fail_total;
    assign pending          = queue_depth;
    assign results_seen     = result_total;
    assign func_errors_seen = error_total;
    assign states_seen      = visited;

    // control word driven in each state
    function automatic logic [CwWidth-1:0] word_for_state(input logic [StateWidth-1:0] s);
        case (s)
            ST_FETCH:     return 19'h12810;
            ST_DECODE:    return 19'h00030;
            ST_MEM_ADDR:  return 19'h00028;
            ST_MEM_READ:  return 19'h03000;
            ST_LOAD_WB:   return 19'h20004;
            ST_MEM_WRITE: return 19'h05000;
            ST_R_EXEC:    return 19'h00088;
            ST_R_WB:      return 19'h00005;
            ST_BEQ:       return 19'h00548;
            ST_J:         return 19'h00A00;
            ST_JAL:       return 19'h40A06;
            ST_JR:        return 19'h00B00;
            ST_JALR:      return 19'h40B04;
            ST_ADDI_EXEC: return 19'h00028;
            ST_ANDI_EXEC: return 19'h000E8;
            ST_BNE:       return 19'h08548;
            ST_IMM_WB:    return 19'h00004;
            default:      return '0;
        endcase
    endfunction

    // state transition; opcode only matters in decode and memory address
    function automatic logic [StateWidth-1:0] following_state(
        input logic [StateWidth-1:0]  s,
        input logic [OpcodeWidth-1:0] op
    );
        case (s)
            ST_FETCH:
                return ST_DECODE;
            ST_DECODE:
                case (op)
                    OP_RTYPE:     return ST_R_EXEC;
                    OP_LW, OP_SW: return ST_MEM_ADDR;
                    OP_BEQ:       return ST_BEQ;
                    OP_BNE:       return ST_BNE;
                    OP_J:         return ST_J;
                    OP_JAL:       return ST_JAL;
                    OP_JR:        return ST_JR;
                    OP_JALR:      return ST_JALR;
                    OP_ADDI:      return ST_ADDI_EXEC;
                    OP_ANDI:      return ST_ANDI_EXEC;
                    default:      return ST_FETCH;
                endcase
            ST_MEM_ADDR:
                if (op == OP_LW)
                    return ST_MEM_READ;
                else if (op == OP_SW)
                    return ST_MEM_WRITE;
                else
                    return ST_FETCH;
            ST_MEM_READ:                return ST_LOAD_WB;
            ST_R_EXEC:                  return ST_R_WB;
            ST_ADDI_EXEC, ST_ANDI_EXEC: return ST_IMM_WB;
            default:                    return ST_FETCH;
        endcase
    endfunction

    task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
        fail_total++;
        if (fail_total <= MaxPrinted)
            $display("%0t ns mismatch on %s: expected 0x%0h got 0x%0h", $time, what, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_state = ST_FETCH;
            held_alu  = ALU_AND;
            expected_ctl_q.delete();
            queue_depth = 0;
        end
        else
        begin
            // result beat: compare against the oldest prediction
            if (rsp_valid && !rsp_stall)
            begin
                result_total++;
                if (present_state < NumStates)
                    visited[present_state] = 1'b1;
                if (func_error === 1'b1)
                    error_total++;
                if (expected_ctl_q.size() == 0)
                    report("unexpected result beat, control_word", '0, 32'(control_word));
                else
                begin
                    oldest_beat = expected_ctl_q.pop_front();
                    if (control_word !== oldest_beat.control_word)
                        report("control_word", 32'(oldest_beat.control_word),
                               32'(control_word));
                    if (alu_operation !== oldest_beat.alu_operation)
                        report("alu_operation", 32'(oldest_beat.alu_operation),
                               32'(alu_operation));
                    if (func_error !== oldest_beat.func_error)
                        report("func_error", 32'(oldest_beat.func_error),
                               32'(func_error));
                    if (present_state !== oldest_beat.present_state)
                        report("present_state", 32'(oldest_beat.present_state),
                               32'(present_state));
                end
            end

            // request beat: output of the present state, then step
            if (req_valid && !req_stall)
            begin
                cw = word_for_state(ctl_state);
                next_beat.func_error = 1'b0;
                case (cw[7:6])
                    ALUOP_FUNC:
                        case (func_code)
                            FN_ADD:  held_alu = ALU_ADD;
                            FN_SUB:  held_alu = ALU_SUB;
                            FN_SLT:  held_alu = ALU_SLT;
                            FN_AND:  held_alu = ALU_AND;
                            FN_OR:   held_alu = ALU_OR;
                            // unknown function code keeps the previous operation
                            default: next_beat.func_error = 1'b1;
                        endcase
                    ALUOP_AND: held_alu = ALU_AND;
                    ALUOP_SUB: held_alu = ALU_SUB;
                    default:   held_alu = ALU_ADD;
                endcase
                next_beat.control_word  = cw;
                next_beat.alu_operation = held_alu;
                next_beat.present_state = ctl_state;
                expected_ctl_q.push_back(next_beat);
                ctl_state = following_state(ctl_state, opcode);
            end

            queue_depth = expected_ctl_q.size();
        end
    end

endmodule

// ===== dv/multicycle_cpu_control_unit_core_tb.sv =====
// Testbench top for the multicycle control unit: clock, reset, instruction stimulus
// with random idling on both channels, and the verdict. Depends on mccu_pkg,
// mccu_control_checker and multicycle_cpu_control_unit_core.
`timescale 1ns / 1ps

module multicycle_cpu_control_unit_core_tb;
    import mccu_pkg::*;

    localparam int RandomBeats = 660;
    localparam int NoiseBeats  = 40;
    localparam int DrainCycles = 20;
    localparam int CycleLimit  = 400000;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_stall;
    logic [OpcodeWidth-1:0] opcode    = '0;
    logic [FuncWidth-1:0]   func_code = '0;
    logic                   rsp_valid;
    logic                   rsp_stall = 1'b0;
    logic [CwWidth-1:0]     control_word;
    logic [AluWidth-1:0]    alu_operation;
    logic                   func_error;
    logic [StateWidth-1:0]  present_state;

    int          mismatches;
    int          pending;
    int          results_seen;
    int          func_errors_seen;
    logic [16:0] states_seen;

    int   beats_sent    = 0;
    int   instr_sent    = 0;
    int   cycle_count   = 0;
    int   stall_left    = 0;
    bit   tx_quiet      = 1'b0;
    bit   rx_quiet      = 1'b0;
    bit   draining      = 1'b0;
    logic rsp_taken     = 1'b0;

    logic [OpcodeWidth-1:0] routed_ops [11] = '{OP_RTYPE, OP_LW, OP_SW, OP_BEQ, OP_BNE,
                                                OP_J, OP_JAL, OP_JR, OP_JALR, OP_ADDI, OP_ANDI};
    logic [FuncWidth-1:0]   known_funcs [5] = '{FN_ADD, FN_SUB, FN_AND, FN_OR, FN_SLT};

    multicycle_cpu_control_unit_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .opcode        (opcode),
        .func_code     (func_code),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .control_word  (control_word),
        .alu_operation (alu_operation),
        .func_error    (func_error),
        .present_state (present_state)
    );

    mccu_control_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req_valid),
        .req_stall        (req_stall),
        .opcode           (opcode),
        .func_code        (func_code),
        .rsp_valid        (rsp_valid),
        .rsp_stall        (rsp_stall),
        .control_word     (control_word),
        .alu_operation    (alu_operation),
        .func_error       (func_error),
        .present_state    (present_state),
        .mismatches       (mismatches),
        .pending          (pending),
        .results_seen     (results_seen),
        .func_errors_seen (func_errors_seen),
        .states_seen      (states_seen)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending);
            $display("Verification failed");
            $finish;
        end
    end

    // result side: random stall drawn after each accepted result beat
    always @(posedge clk)
    begin
        rsp_taken <= rsp_valid && !rsp_stall;
    end

    always @(negedge clk)
    begin
        if (draining)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_taken)
            begin
                if ($urandom_range(0, 31) == 0)
                    rx_quiet = !rx_quiet;
                stall_left = rx_quiet ? 0 : $urandom_range(0, 19);
            end
            if (stall_left > 0)
            begin
                rsp_stall <= 1'b1;
                stall_left--;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    // one request beat: optional gap, then hold until accepted; ends on a falling edge
    task automatic drive_request_beat(input logic [OpcodeWidth-1:0] op,
                                      input logic [FuncWidth-1:0]   fn);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        opcode    <= op;
        func_code <= fn;
        do
            @(posedge clk);
        while (req_stall);
        beats_sent++;
        @(negedge clk);
    endtask

    // one instruction from fetch onward; fields the machine ignores get random values
    task automatic run_instruction(input logic [OpcodeWidth-1:0] op,
                                   input logic [FuncWidth-1:0]   exec_fn,
                                   input bit                     broken_mem);
        int                     len;
        logic [OpcodeWidth-1:0] beat_op;
        logic [FuncWidth-1:0]   beat_fn;
        case (op)
            OP_LW:                                        len = broken_mem ? 3 : 5;
            OP_SW:                                        len = broken_mem ? 3 : 4;
            OP_RTYPE, OP_ADDI, OP_ANDI:                   len = 4;
            OP_BEQ, OP_BNE, OP_J, OP_JAL, OP_JR, OP_JALR: len = 3;
            default:                                      len = 2;
        endcase
        for (int b = 0; b < len; b++)
        begin
            beat_op = OpcodeWidth'($urandom_range(0, 63));
            beat_fn = FuncWidth'($urandom_range(0, 63));
            if (b == 1)
                beat_op = op;
            if (b == 2 && (op == OP_LW || op == OP_SW))
            begin
                // a broken load or store sees some other opcode in address phase
                if (broken_mem)
                    while (beat_op == OP_LW || beat_op == OP_SW)
                        beat_op = OpcodeWidth'($urandom_range(0, 63));
                else
                    beat_op = op;
            end
            if (b == 2 && op == OP_RTYPE)
                beat_fn = exec_fn;
            drive_request_beat(beat_op, beat_fn);
        end
        instr_sent++;
    endtask

    // stimulus and verdict
    initial
    begin
        int pick;
        logic [FuncWidth-1:0] fn;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: every routed opcode, unknown function codes at both extremes,
        // an opcode with no route, and a load broken in its address phase
        run_instruction(OP_RTYPE, 6'h00, 1'b0);
        run_instruction(OP_RTYPE, FN_SLT, 1'b0);
        run_instruction(OP_RTYPE, 6'h3f, 1'b0);
        for (int i = 0; i < 11; i++)
            run_instruction(routed_ops[i], FN_OR, 1'b0);
        run_instruction(6'h3f, 6'h3f, 1'b0);
        run_instruction(OP_LW, 6'h00, 1'b1);

        // random well-formed instructions with some unknown opcodes and broken loads and stores
        while (beats_sent < RandomBeats)
        begin
            if ($urandom_range(0, 15) == 0)
                tx_quiet = !tx_quiet;
            pick = $urandom_range(0, 99);
            fn = ($urandom_range(0, 3) == 0) ? FuncWidth'($urandom_range(0, 63))
                                              : known_funcs[$urandom_range(0, 4)];
            if (pick < 80)
                run_instruction(routed_ops[$urandom_range(0, 10)], fn, 1'b0);
            else if (pick < 90)
                run_instruction(OpcodeWidth'($urandom_range(0, 63)), fn, 1'b0);
            else
                run_instruction(($urandom_range(0, 1) == 0) ? OP_LW : OP_SW, fn, 1'b1);
        end

        // pure noise to finish
        repeat (NoiseBeats)
            drive_request_beat(OpcodeWidth'($urandom_range(0, 63)),
                               FuncWidth'($urandom_range(0, 63)));
        req_valid <= 1'b0;

        // drain, then watch for stray results
        while (pending != 0)
            @(negedge clk);
        draining = 1'b1;
        repeat (DrainCycles) @(negedge clk);

        $display("Covered %0d request beats over %0d instructions, %0d results checked",
                 beats_sent, instr_sent, results_seen);
        $display("%0d of 17 control states seen, %0d unknown function codes flagged",
                 $countones(states_seen), func_errors_seen);
        if (mismatches == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
